// ===== design/lut3d_trilinear_color_grade_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the 3D LUT color grade block
// Checks vanish in synthesis and stay in simulation.
// ----------------------------------------------------------------------------
`ifndef LUT3D_TRILINEAR_COLOR_GRADE_TOP_MACROS_SVH
`define LUT3D_TRILINEAR_COLOR_GRADE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge out of reset.
`define LUT3D_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lut3d assertion failed");
// A signal that must keep its value in the cycle after a condition.
`define LUT3D_HOLD(lbl, clk, rst_n, cond, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error("lut3d hold check failed");
`else
`define LUT3D_ASSERT(lbl, clk, rst_n, prop)
`define LUT3D_HOLD(lbl, clk, rst_n, cond, sig)
`endif
`endif

// ===== design/lut3d_pkg.sv =====
// ----------------------------------------------------------------------------
// lut3d_pkg
// Shared constants and arithmetic helpers of the 3D LUT color grade block.
// ----------------------------------------------------------------------------
`default_nettype none

package lut3d_pkg;

  localparam int GRID_POINTS_DEF = 33;
  localparam int FRAC_BITS_DEF   = 12;
  localparam int FRAC_MAX        = 16;
  localparam int VAL_W           = 16;
  localparam int POS_IN_W        = 6;
  localparam int PIX_W           = 8;
  localparam int STR_W           = 13;
  localparam int VAL_ONE         = 4096;
  localparam int LERP_W          = 40;
  localparam int BLEND_W         = 40;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  // Grid position of a channel value in Q(fb), rounded down.
  function automatic longint grid_pos(input int c, input int gp, input int fb);
    longint num;
    num = longint'(c) * longint'(gp - 1);
    num = num << fb;
    return num / 255;
  endfunction

  // One interpolation step, rounded half up.
  function automatic logic signed [VAL_W-1:0] lerp_q(
    input logic signed [VAL_W-1:0] a,
    input logic signed [VAL_W-1:0] b,
    input logic [FRAC_MAX:0]       t,
    input int                      fb
  );
    logic [FRAC_MAX:0]        one;
    logic signed [LERP_W-1:0] acc;
    one = (FRAC_MAX+1)'(1) << fb;
    acc = LERP_W'(a) * LERP_W'($signed({1'b0, one - t}))
        + LERP_W'(b) * LERP_W'($signed({1'b0, t}))
        + $signed(LERP_W'(one >> 1));
    return VAL_W'(acc >>> fb);
  endfunction

endpackage

`default_nettype wire

// ===== design/lut3d_trilinear_color_grade_top.sv =====
// ----------------------------------------------------------------------------
// lut3d_trilinear_color_grade_top
// 3D LUT color grade with trilinear interpolation and strength blend.
// ----------------------------------------------------------------------------
// The block takes one beat per clock while in_stall is low, load or pixel
// alike, and a pixel's result passes through every stage and then the output
// register before it appears on the output. The node store is split into eight
// banks by the parity of the three grid coordinates, so the eight corners of
// any cell are read from eight different banks in one cycle; that bank read
// sets the one-beat-per-clock rate. A load writes its node from stage 0 when
// the pipeline next advances, and a pixel taken later always sees it. Nodes
// are not cleared at reset: load every node a pixel can reach before sending
// pixels. All stages advance together whenever the output register is free or
// being taken, so in_stall follows out_stall while a result waits.
`default_nettype none

module lut3d_trilinear_color_grade_top #(
  parameter int GRID_POINTS = lut3d_pkg::GRID_POINTS_DEF,
  parameter int FRAC_BITS   = lut3d_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [lut3d_pkg::STR_W-1:0]         cfg_blend_strength,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_kind,
  input  wire logic [lut3d_pkg::PIX_W-1:0]         in_pix_red,
  input  wire logic [lut3d_pkg::PIX_W-1:0]         in_pix_green,
  input  wire logic [lut3d_pkg::PIX_W-1:0]         in_pix_blue,
  input  wire logic [lut3d_pkg::POS_IN_W-1:0]      in_node_red_pos,
  input  wire logic [lut3d_pkg::POS_IN_W-1:0]      in_node_green_pos,
  input  wire logic [lut3d_pkg::POS_IN_W-1:0]      in_node_blue_pos,
  input  wire logic signed [lut3d_pkg::VAL_W-1:0]  in_node_red_val,
  input  wire logic signed [lut3d_pkg::VAL_W-1:0]  in_node_green_val,
  input  wire logic signed [lut3d_pkg::VAL_W-1:0]  in_node_blue_val,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [lut3d_pkg::PIX_W-1:0]              out_red,
  output logic [lut3d_pkg::PIX_W-1:0]              out_green,
  output logic [lut3d_pkg::PIX_W-1:0]              out_blue
);

  import lut3d_pkg::*;

  `include "lut3d_trilinear_color_grade_top_macros.svh"

  localparam int IDX_W  = $clog2(GRID_POINTS);
  localparam int POS_W  = IDX_W + FRAC_BITS;
  localparam int HALF   = (GRID_POINTS + 1) / 2;
  localparam int HW     = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int DEPTH  = HALF * HALF * HALF;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NODE_W = 3 * VAL_W;
  localparam int GPC_W  = POS_IN_W + 1;

  // Output register state, read by the advance logic.
  logic             out_valid_r;
  logic [PIX_W-1:0] out_byte_r [3];

  // Global advance: every stage moves when the output slot can take a beat.
  logic adv;
  assign adv       = !(out_valid_r && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  // Strength register.
  logic [STR_W-1:0] strength_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strength_r <= STR_W'(VAL_ONE);
    end else if (cfg_valid && cfg_ready) begin
      strength_r <= cfg_blend_strength;
    end
  end

  // Grid position table over all channel values.
  logic [POS_W-1:0] pos_tbl [256];
  for (genvar k = 0; k < 256; k++) begin : g_pos
    assign pos_tbl[k] = POS_W'(grid_pos(k, GRID_POINTS, FRAC_BITS));
  end

  logic [POS_W-1:0] pos_r, pos_g, pos_b;
  assign pos_r = pos_tbl[in_pix_red];
  assign pos_g = pos_tbl[in_pix_green];
  assign pos_b = pos_tbl[in_pix_blue];

  // Stage 0: registered input beat with its grid split.
  logic                    s0_vld_r, s0_kind_r;
  logic [PIX_W-1:0]        s0_pix_r [3];
  logic [IDX_W-1:0]        s0_idx_r [3];
  logic [FRAC_BITS-1:0]    s0_t_r   [3];
  logic [POS_IN_W-1:0]     s0_npos_r [3];
  logic [NODE_W-1:0]       s0_nval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_kind_r    <= in_kind;
      s0_pix_r[0]  <= in_pix_red;
      s0_pix_r[1]  <= in_pix_green;
      s0_pix_r[2]  <= in_pix_blue;
      s0_idx_r[0]  <= pos_r[POS_W-1:FRAC_BITS];
      s0_idx_r[1]  <= pos_g[POS_W-1:FRAC_BITS];
      s0_idx_r[2]  <= pos_b[POS_W-1:FRAC_BITS];
      s0_t_r[0]    <= pos_r[FRAC_BITS-1:0];
      s0_t_r[1]    <= pos_g[FRAC_BITS-1:0];
      s0_t_r[2]    <= pos_b[FRAC_BITS-1:0];
      s0_npos_r[0] <= in_node_red_pos;
      s0_npos_r[1] <= in_node_green_pos;
      s0_npos_r[2] <= in_node_blue_pos;
      s0_nval_r    <= {in_node_red_val, in_node_green_val, in_node_blue_val};
    end
  end

  // Per-axis lower parity and edge clamp of the pixel in stage 0.
  logic [2:0] s0_par, s0_clamp;
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      s0_par[a]   = s0_idx_r[a][0];
      s0_clamp[a] = (s0_idx_r[a] == IDX_W'(GRID_POINTS - 1));
    end
  end

  // Load write address and enable.
  logic              mem_we;
  logic [2:0]        w_bank;
  logic [ADDR_W-1:0] w_addr;
  logic              w_in_range;
  always_comb begin
    w_in_range = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (GPC_W'(s0_npos_r[a]) >= GPC_W'(GRID_POINTS)) begin
        w_in_range = 1'b0;
      end
      w_bank[2-a] = s0_npos_r[a][0];
    end
    w_addr = ADDR_W'((int'(s0_npos_r[0] >> 1) * HALF + int'(s0_npos_r[1] >> 1)) * HALF
                     + int'(s0_npos_r[2] >> 1));
    mem_we = adv && s0_vld_r && (s0_kind_r == KIND_LOAD) && w_in_range;
  end

  // Eight parity banks; bank q = {red, green, blue} parity.
  logic [NODE_W-1:0] rd [8];
  for (genvar q = 0; q < 8; q++) begin : g_bank
    localparam logic [2:0] BANK_ID = 3'(q);
    logic [IDX_W-1:0]  crd [3];
    logic [ADDR_W-1:0] r_addr;
    always_comb begin
      for (int a = 0; a < 3; a++) begin
        if (s0_clamp[a] || (s0_par[a] == BANK_ID[2-a])) begin
          crd[a] = s0_idx_r[a];
        end else begin
          crd[a] = s0_idx_r[a] + IDX_W'(1);
        end
      end
      r_addr = ADDR_W'((int'(HW'(crd[0] >> 1)) * HALF + int'(HW'(crd[1] >> 1))) * HALF
                       + int'(HW'(crd[2] >> 1)));
    end
    lut3d_bank #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (NODE_W)
    ) u_bank (
      .clk   (clk),
      .we    (mem_we && (w_bank == BANK_ID)),
      .waddr (w_addr),
      .wdata (s0_nval_r),
      .re    (adv),
      .raddr (r_addr),
      .rdata (rd[q])
    );
  end

  // Stage 1: side data beside the bank read.
  logic                 s1_vld_r;
  logic [PIX_W-1:0]     s1_pix_r [3];
  logic [FRAC_BITS-1:0] s1_t_r   [3];
  logic [2:0]           s1_par_r, s1_clamp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= s0_vld_r && (s0_kind_r == KIND_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pix_r   <= s0_pix_r;
      s1_t_r     <= s0_t_r;
      s1_par_r   <= s0_par;
      s1_clamp_r <= s0_clamp;
    end
  end

  // Corner selection: a clamped upper neighbor reuses the lower bank.
  logic signed [VAL_W-1:0] corner [3][8];
  always_comb begin
    logic [2:0] bsel;
    for (int cidx = 0; cidx < 8; cidx++) begin
      for (int a = 0; a < 3; a++) begin
        if (cidx[2-a]) begin
          bsel[2-a] = s1_clamp_r[a] ? s1_par_r[a] : !s1_par_r[a];
        end else begin
          bsel[2-a] = s1_par_r[a];
        end
      end
      for (int ch = 0; ch < 3; ch++) begin
        corner[ch][cidx] = rd[bsel][NODE_W-1-ch*VAL_W -: VAL_W];
      end
    end
  end

  // Stage 2: interpolation along red (corner index bits are r, g, b).
  logic                    s2_vld_r;
  logic [PIX_W-1:0]        s2_pix_r [3];
  logic [FRAC_BITS-1:0]    s2_tg_r, s2_tb_r;
  logic signed [VAL_W-1:0] s2_x_r [3][4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_pix_r <= s1_pix_r;
      s2_tg_r  <= s1_t_r[1];
      s2_tb_r  <= s1_t_r[2];
      for (int ch = 0; ch < 3; ch++) begin
        for (int gb = 0; gb < 4; gb++) begin
          s2_x_r[ch][gb] <= lerp_q(corner[ch][gb], corner[ch][gb + 4],
                                   (FRAC_MAX+1)'(s1_t_r[0]), FRAC_BITS);
        end
      end
    end
  end

  // Stage 3: interpolation along green.
  logic                    s3_vld_r;
  logic [PIX_W-1:0]        s3_pix_r [3];
  logic [FRAC_BITS-1:0]    s3_tb_r;
  logic signed [VAL_W-1:0] s3_y_r [3][2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_pix_r <= s2_pix_r;
      s3_tb_r  <= s2_tb_r;
      for (int ch = 0; ch < 3; ch++) begin
        for (int b = 0; b < 2; b++) begin
          s3_y_r[ch][b] <= lerp_q(s2_x_r[ch][b], s2_x_r[ch][b + 2],
                                  (FRAC_MAX+1)'(s2_tg_r), FRAC_BITS);
        end
      end
    end
  end

  // Stage 4: interpolation along blue.
  logic                    s4_vld_r;
  logic [PIX_W-1:0]        s4_pix_r [3];
  logic signed [VAL_W-1:0] s4_l_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (adv) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_pix_r <= s3_pix_r;
      for (int ch = 0; ch < 3; ch++) begin
        s4_l_r[ch] <= lerp_q(s3_y_r[ch][0], s3_y_r[ch][1],
                             (FRAC_MAX+1)'(s3_tb_r), FRAC_BITS);
      end
    end
  end

  // Stage 5: blend products with the saturated strength.
  logic [STR_W-1:0] s_sat, s_inv;
  assign s_sat = (strength_r > STR_W'(VAL_ONE)) ? STR_W'(VAL_ONE) : strength_r;
  assign s_inv = STR_W'(VAL_ONE) - s_sat;

  logic                                s5_vld_r;
  logic [STR_W+PIX_W-1:0]              s5_p1_r [3];
  logic signed [STR_W+VAL_W:0]         s5_p2_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (adv) begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ch = 0; ch < 3; ch++) begin
        s5_p1_r[ch] <= (STR_W+PIX_W)'(s_inv) * (STR_W+PIX_W)'(s4_pix_r[ch]);
        s5_p2_r[ch] <= (STR_W+VAL_W+1)'($signed({1'b0, s_sat}))
                     * (STR_W+VAL_W+1)'(s4_l_r[ch]);
      end
    end
  end

  // Final sum, round half up and clamp to a byte.
  logic [PIX_W-1:0] byte_nxt [3];
  always_comb begin
    logic signed [BLEND_W-1:0] n;
    logic signed [BLEND_W-1:0] v;
    for (int ch = 0; ch < 3; ch++) begin
      n = $signed(BLEND_W'({s5_p1_r[ch], 12'd0}))
        + (BLEND_W'(s5_p2_r[ch]) <<< 8) - BLEND_W'(s5_p2_r[ch])
        + $signed(BLEND_W'(1) <<< 23);
      v = n >>> 24;
      if (v < 0) begin
        byte_nxt[ch] = '0;
      end else if (v > $signed(BLEND_W'(255))) begin
        byte_nxt[ch] = '1;
      end else begin
        byte_nxt[ch] = PIX_W'(v);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r <= byte_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_byte_r[0];
  assign out_green = out_byte_r[1];
  assign out_blue  = out_byte_r[2];

  // Checks.
  `LUT3D_ASSERT(a_s1_to_s2, clk, rst_n, (adv && s1_vld_r) |=> s2_vld_r)
  `LUT3D_HOLD(a_s4_hold, clk, rst_n, !adv, s4_vld_r)
  `LUT3D_ASSERT(a_we_range, clk, rst_n, mem_we |-> (s0_kind_r == KIND_LOAD && w_in_range))

endmodule

`default_nettype wire

// ===== design/lut3d_bank.sv =====
// ----------------------------------------------------------------------------
// lut3d_bank
// One parity bank of the node store: one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lut3d_bank #(
  parameter int DEPTH  = 4913,
  parameter int ADDR_W = 13,
  parameter int DATA_W = 48
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while the pipeline is stalled.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
